// File: src/slsgd_pkg.sv
package slsgd_pkg;

   localparam int INDEX_W  = 16;
   localparam int WEIGHT_W = 32;
   localparam int SUM_W    = 40;
   localparam int PROB_W   = 16;
   localparam int FC_W     = 11;
   localparam int LR_W     = 16;
   localparam int DELTA_W  = 20;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FC_W-1:0]   FEATURE_COUNT_RESET = 11'd1024;
   localparam logic [LR_W-1:0]   LEARNING_RATE_RESET = 16'd3277;
   localparam logic [PROB_W-1:0] PROB_HALF           = 16'd32768;

   localparam logic CSR_IDX_FEATURE_COUNT = 1'b0;
   localparam logic CSR_IDX_LEARNING_RATE = 1'b1;

   typedef enum logic [1:0] {
      MODE_TRAIN   = 2'd0,
      MODE_PREDICT = 2'd1,
      MODE_WRITE   = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_WRITE,
      ST_READ_OUT,
      ST_ACCUM,
      ST_CLAMP,
      ST_TABLE,
      ST_RESULT,
      ST_UPD_IDX,
      ST_UPD_RD,
      ST_UPD_WR
   } state_type;

   typedef struct packed {
      logic [FC_W-1:0] feature_count;
      logic [LR_W-1:0] learning_rate;
   } cfg_type;

endpackage

// File: src/sparse_logistic_sgd_engine.sv
// Sparse logistic regression engine. After reset the weight table is cleared one
// entry per clock with busy high; CSR writes are taken meanwhile. An item is taken
// when start is high and busy is low. A weight write passes the write state; a weight
// read passes fetch and read-out, a non-final feature fetch and accumulate, a final
// feature also clamp, table and result, and in train mode an update per buffered index
// that reads the sample buffer, then reads and writes the weight RAM. Each result
// appears for exactly one cycle with rsp_strobe high and cannot be stalled by the receiver.
module sparse_logistic_sgd_engine import slsgd_pkg::*; #(
   parameter int FEATURE_DEPTH         = 1024,
   parameter int SAMPLE_BUFFER_DEPTH   = 64,
   parameter int SIGMOID_TABLE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_mode,
   input  logic [INDEX_W-1:0]    req_feature_index,
   input  logic                  req_label,
   input  logic                  req_last,
   input  logic signed [WEIGHT_W-1:0] req_weight_in,
   output logic                  rsp_strobe,
   output logic                  rsp_result_kind,
   output logic [PROB_W-1:0]     rsp_probability,
   output logic                  rsp_predicted_class,
   output logic                  rsp_label_match,
   output logic                  rsp_buffer_overflow,
   output logic signed [WEIGHT_W-1:0] rsp_weight_out,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int AW  = $clog2(FEATURE_DEPTH);
   localparam int SPW = (SAMPLE_BUFFER_DEPTH > 1) ? $clog2(SAMPLE_BUFFER_DEPTH) : 1;
   localparam int FW  = $clog2(SAMPLE_BUFFER_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(FEATURE_DEPTH - 1);

   cfg_type cfg;

   state_type state_ff, state_in;

   mode_type                   mode_ff;
   logic [INDEX_W-1:0]         index_ff;
   logic                       label_ff;
   logic                       last_ff;
   logic [WEIGHT_W-1:0]        wdata_ff;

   logic [WEIGHT_W-1:0]        wmem [FEATURE_DEPTH];
   logic [WEIGHT_W-1:0]        rdata_ff;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [WEIGHT_W-1:0]        wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;

   logic [AW-1:0]              smem [SAMPLE_BUFFER_DEPTH];
   logic [AW-1:0]              sbuf_q_ff;
   logic                       sb_we;
   logic                       sb_re;

   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic                       ovf_ff, ovf_in;
   logic [SPW-1:0]             ptr_ff, ptr_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic signed [DELTA_W-1:0]  delta_ff, delta_in;

   logic                       accept;
   logic                       in_depth;
   logic                       in_limit;
   logic                       sig_load;
   logic [PROB_W-1:0]          prob;
   logic                       cls;
   logic signed [SUM_W:0]      sum_ext;
   logic signed [17:0]         grad;
   logic signed [35:0]         prod;
   logic signed [WEIGHT_W+1:0] upd;
   logic [WEIGHT_W-1:0]        upd_sat;

   slsgd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   slsgd_sigmoid #(
      .TABLE_ENTRIES (SIGMOID_TABLE_ENTRIES)
   ) u_sigmoid (
      .clock       (clock),
      .load        (sig_load),
      .sum         (sum_ff),
      .probability (prob)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_depth = {1'b0, index_ff} < 17'(FEATURE_DEPTH);
   assign in_limit = in_depth && (index_ff < INDEX_W'(cfg.feature_count));
   assign cls      = prob > PROB_HALF;

   always_comb begin
      sum_ext = {sum_ff[SUM_W-1], sum_ff} +
                {{(SUM_W + 1 - WEIGHT_W){rdata_ff[WEIGHT_W-1]}}, rdata_ff};
      grad    = $signed({2'b00, prob}) - (label_ff ? 18'sd65536 : 18'sd0);
      prod    = 36'(grad) * $signed({20'd0, cfg.learning_rate});
      prod    = prod + 36'sd32768;
      upd     = {{2{rdata_ff[WEIGHT_W-1]}}, rdata_ff} -
                {{(WEIGHT_W + 2 - DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
      if (upd[WEIGHT_W+1:WEIGHT_W-1] == 3'b000 || upd[WEIGHT_W+1:WEIGHT_W-1] == 3'b111) begin
         upd_sat = upd[WEIGHT_W-1:0];
      end else if (upd[WEIGHT_W+1]) begin
         upd_sat = 32'h8000_0000;
      end else begin
         upd_sat = 32'h7FFF_FFFF;
      end
   end

   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      fill_in  = fill_ff;
      ovf_in   = ovf_ff;
      ptr_in   = ptr_ff;
      clr_in   = clr_ff;
      delta_in = delta_ff;
      wr_en    = 1'b0;
      wr_addr  = index_ff[AW-1:0];
      wr_data  = wdata_ff;
      rd_en    = 1'b0;
      rd_addr  = index_ff[AW-1:0];
      sb_we    = 1'b0;
      sb_re    = 1'b0;
      sig_load = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (mode_type'(req_mode) == MODE_WRITE) ? ST_WRITE : ST_FETCH;
            end
         end
         ST_WRITE: begin
            wr_en    = in_depth;
            state_in = ST_IDLE;
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            state_in = (mode_ff == MODE_READ) ? ST_READ_OUT : ST_ACCUM;
         end
         ST_READ_OUT: begin
            state_in = ST_IDLE;
         end
         ST_ACCUM: begin
            if (in_limit) begin
               if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                  sum_in = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                          : {1'b0, {(SUM_W - 1){1'b1}}};
               end else begin
                  sum_in = sum_ext[SUM_W-1:0];
               end
               if (fill_ff < FW'(SAMPLE_BUFFER_DEPTH)) begin
                  sb_we   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            state_in = last_ff ? ST_CLAMP : ST_IDLE;
         end
         ST_CLAMP: begin
            sig_load = 1'b1;
            state_in = ST_TABLE;
         end
         ST_TABLE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            delta_in = prod[35:16];
            sum_in   = '0;
            ovf_in   = 1'b0;
            ptr_in   = '0;
            if (mode_ff == MODE_TRAIN && fill_ff != '0) begin
               state_in = ST_UPD_IDX;
            end else begin
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_UPD_IDX: begin
            sb_re    = 1'b1;
            state_in = ST_UPD_RD;
         end
         ST_UPD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = sbuf_q_ff;
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            wr_en   = 1'b1;
            wr_addr = sbuf_q_ff;
            wr_data = upd_sat;
            ptr_in  = ptr_ff + SPW'(1);
            if (FW'(ptr_ff) + FW'(1) == fill_ff) begin
               fill_in  = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPD_IDX;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         ptr_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         sum_ff   <= sum_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         ptr_ff   <= ptr_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      if (accept) begin
         mode_ff  <= mode_type'(req_mode);
         index_ff <= req_feature_index;
         label_ff <= req_label;
         last_ff  <= req_last;
         wdata_ff <= req_weight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= wmem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sb_we) begin
         smem[fill_ff[SPW-1:0]] <= index_ff[AW-1:0];
      end
      if (sb_re) begin
         sbuf_q_ff <= smem[ptr_ff];
      end
   end

   assign rsp_strobe          = (state_ff == ST_RESULT) || (state_ff == ST_READ_OUT);
   assign rsp_result_kind     = (state_ff == ST_READ_OUT);
   assign rsp_probability     = (state_ff == ST_RESULT) ? prob : '0;
   assign rsp_predicted_class = (state_ff == ST_RESULT) && cls;
   assign rsp_label_match     = (state_ff == ST_RESULT) && (cls == label_ff);
   assign rsp_buffer_overflow = (state_ff == ST_RESULT) && ovf_ff;
   assign rsp_weight_out      = ((state_ff == ST_READ_OUT) && in_depth) ? rdata_ff : '0;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted beat");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(SAMPLE_BUFFER_DEPTH))
      else $error("sample fill beyond buffer depth");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_kind) |->
         (rsp_probability == '0 && !rsp_predicted_class && !rsp_label_match &&
          !rsp_buffer_overflow))
      else $error("sample fields set on a weight read beat");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");
`endif

endmodule

// File: src/slsgd_csr.sv
module slsgd_csr import slsgd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_beat;

   assign wr_beat = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (paddr[2])
            CSR_IDX_FEATURE_COUNT: cfg_in.feature_count = pwdata[FC_W-1:0];
            CSR_IDX_LEARNING_RATE: cfg_in.learning_rate = pwdata[LR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_FEATURE_COUNT: prdata = CSR_DATA_W'(cfg_ff.feature_count);
         CSR_IDX_LEARNING_RATE: prdata = CSR_DATA_W'(cfg_ff.learning_rate);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feature_count <= FEATURE_COUNT_RESET;
         cfg_ff.learning_rate <= LEARNING_RATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/slsgd_sigmoid.sv
module slsgd_sigmoid import slsgd_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic signed [SUM_W-1:0] sum,
   output logic [PROB_W-1:0]       probability
);

   localparam int TW = $clog2(TABLE_ENTRIES);
   localparam int PW = 20 + $clog2(TABLE_ENTRIES + 1);
   localparam logic signed [SUM_W-1:0] CLAMP_LO = -40'sd524288;
   localparam logic signed [SUM_W-1:0] CLAMP_HI = 40'sd524287;

   function automatic logic [PROB_W-1:0] sig_entry(input longint x);
      longint unsigned one;
      longint unsigned y;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned t3;
      longint unsigned t4;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      longint unsigned dividend;
      longint unsigned rem;
      longint unsigned q;
      int k;
      one = 64'h8000_0000;
      y = (x < 0) ? longint'(-x) : longint'(x);
      t  = y << 7;
      t2 = (t * t) >> 31;
      t3 = (t2 * t) >> 31;
      t4 = (t3 * t) >> 31;
      e  = one - t + (t2 >> 1) - t3 / 6 + t4 / 24;
      for (k = 0; k < 8; k++) begin
         e = (e * e) >> 31;
      end
      num = (x >= 0) ? one : e;
      den = one + e;
      dividend = (num << 16) + (den >> 1);
      rem = 0;
      q = 0;
      for (k = 49; k >= 0; k--) begin
         rem = (rem << 1) | ((dividend >> k) & 64'd1);
         if (rem >= den) begin
            rem = rem - den;
            q = q | (64'd1 << k);
         end
      end
      if (q > 64'd65535) begin
         q = 64'd65535;
      end
      return q[PROB_W-1:0];
   endfunction

   logic [PROB_W-1:0]       rom [TABLE_ENTRIES];
   logic [TW-1:0]           tidx_ff;
   logic [PROB_W-1:0]       prob_ff;
   logic signed [19:0]      clamped;
   logic [19:0]             offset;
   logic [PW-1:0]           scaled;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_rom
      localparam longint XI =
         ((longint'(i) <<< 20) / TABLE_ENTRIES) - (longint'(1) <<< 19);
      assign rom[i] = sig_entry(XI);
   end

   always_comb begin
      if (sum < CLAMP_LO) begin
         clamped = CLAMP_LO[19:0];
      end else if (sum > CLAMP_HI) begin
         clamped = CLAMP_HI[19:0];
      end else begin
         clamped = sum[19:0];
      end
      offset = clamped ^ 20'h80000;
      scaled = PW'(offset) * PW'(TABLE_ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tidx_ff <= scaled[20 +: TW];
      end
      prob_ff <= rom[tidx_ff];
   end

   assign probability = prob_ff;

endmodule
